@@ design/packed_pixel_to_rgb555_unpacker_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Packed pixel unpacker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_TO_RGB555_UNPACKER_UNIT_MACROS_SVH
`define PACKED_PIXEL_TO_RGB555_UNPACKER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PPRU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication from a trigger to a condition on the following edge.
`define PPRU_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ design/ppru_pkg.sv @@
// ----------------------------------------------------------------------------
// Packed pixel unpacker package
// Shared constants, register indexes and the pixel job descriptor.
// ----------------------------------------------------------------------------
package ppru_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned BYTE_CNT_W = 12;
  localparam int unsigned PIX_W      = 15;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [PIX_W-1:0] PIX_WHITE = 15'h7FFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 15'h0000;
  localparam logic [PIX_W-1:0] PIX_RED   = 15'h7C00;
  localparam logic [PIX_W-1:0] PIX_GREEN = 15'h03E0;
  localparam logic [PIX_W-1:0] PIX_BLUE  = 15'h001F;

  typedef struct packed {
    logic [7:0] src_byte;
    logic [3:0] count;
    logic       four_bit;
    logic       row_end;
    logic       last_row;
  } ppru_job_t;

endpackage

@@ design/packed_pixel_to_rgb555_unpacker_unit.sv @@
// ----------------------------------------------------------------------------
// Packed pixel to RGB555 unpacker
// Unpacks 1-bit or 4-bit packed bitmap bytes into RGB555 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes arrive on the in_ channel, rows in order, each row padded to
//   a multiple of four bytes. Every accepted beat yields zero to eight pixel
//   beats on the out_ channel; padding bytes and bits past the row width are
//   consumed without output. Mode, width and height are written through the
//   cfg_ port; the user must write them only while the block is idle, as the
//   block itself does not enforce it. Any write to a defined register
//   restarts the image at its first byte. An accepted byte waits in the job
//   register, and its pixels pass one at a time through the result register.
//   Throughput: one pixel per cycle unless out_ready stalls, set by the single
//   result register; the next byte is taken in the cycle its last pixel moves
//   to the result register.
//   Reset selects 1-bit mode, a 1 by 1 image and clears all counters.
//   When the receiver stalls, the result register holds its beat and the
//   generator stops until out_ready returns; input stops once a byte waits.
// ----------------------------------------------------------------------------
`include "packed_pixel_to_rgb555_unpacker_unit_macros.svh"

module packed_pixel_to_rgb555_unpacker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_pixel_rgb555,
  output logic        out_row_end,
  output logic        out_image_end,
  output logic        out_last_of_byte,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_write_data
);
  import ppru_pkg::*;

  logic                  mode_r;
  logic [DIM_W-1:0]      width_r;
  logic [DIM_W-1:0]      height_r;
  logic [DIM_W-1:0]      col_r;
  logic [BYTE_CNT_W-1:0] rbc_r;
  logic [DIM_W-1:0]      row_r;

  logic [DIM_W-1:0]      eff_w;
  logic [DIM_W-1:0]      eff_h;
  logic [DIM_W:0]        sum_a;
  logic [DIM_W:0]        sum_b;
  logic [BYTE_CNT_W-1:0] data_bytes;
  logic [BYTE_CNT_W-1:0] row_bytes;
  logic [DIM_W-1:0]      left;
  logic [3:0]            per_byte;
  logic [3:0]            n_pix;
  logic                  produce;
  logic [BYTE_CNT_W-1:0] rbc_inc;
  logic [DIM_W-1:0]      row_inc;
  logic                  in_fire;
  logic                  cfg_hit;
  logic                  counters_zero;
  ppru_job_t             job;

  always_comb begin
    if (width_r == '0) begin
      eff_w = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  always_comb begin
    if (mode_r) begin
      sum_a      = {1'b0, eff_w} + 14'd1;
      sum_b      = {1'b0, eff_w} + 14'd7;
      data_bytes = sum_a[BYTE_CNT_W:1];
      row_bytes  = {sum_b[BYTE_CNT_W:3], 2'b00};
      per_byte   = 4'd2;
    end else begin
      sum_a      = {1'b0, eff_w} + 14'd7;
      sum_b      = {1'b0, eff_w} + 14'd31;
      data_bytes = {1'b0, sum_a[BYTE_CNT_W+1:3]};
      row_bytes  = {1'b0, sum_b[BYTE_CNT_W+1:5], 2'b00};
      per_byte   = 4'd8;
    end
  end

  assign left    = eff_w - col_r;
  assign n_pix   = (left < {9'd0, per_byte}) ? left[3:0] : per_byte;
  assign produce = (rbc_r < data_bytes) && (col_r < eff_w);
  assign rbc_inc = rbc_r + 12'd1;
  assign row_inc = row_r + 13'd1;
  assign in_fire = in_valid && in_ready;
  assign cfg_hit = cfg_write_en &&
                   ((cfg_index == REG_MODE) || (cfg_index == REG_WIDTH) ||
                    (cfg_index == REG_HEIGHT));
  assign counters_zero = (col_r == '0) && (rbc_r == '0) && (row_r == '0);

  always_comb begin
    job.src_byte = in_source_byte;
    job.count    = n_pix;
    job.four_bit = mode_r;
    job.row_end  = ((col_r + {9'd0, n_pix}) == eff_w);
    job.last_row = (row_r == (eff_h - 13'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_write_data[0];
        REG_WIDTH:  width_r  <= cfg_write_data;
        REG_HEIGHT: height_r <= cfg_write_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      col_r <= '0;
      rbc_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (rbc_inc >= row_bytes) begin
        rbc_r <= '0;
        col_r <= '0;
        row_r <= (row_inc >= eff_h) ? '0 : row_inc;
      end else begin
        rbc_r <= rbc_inc;
        if (produce) begin
          col_r <= col_r + {9'd0, n_pix};
        end
      end
    end
  end

  ppru_pixel_gen u_pixel_gen (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_load         (in_fire && produce),
    .job              (job),
    .job_ready        (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_rgb555 (out_pixel_rgb555),
    .out_row_end      (out_row_end),
    .out_image_end    (out_image_end),
    .out_last_of_byte (out_last_of_byte)
  );

  `PPRU_ASSERT_ALWAYS(a_col_in_row, col_r <= eff_w, "column count past row width")
  `PPRU_ASSERT_ALWAYS(a_rbc_in_row, rbc_r < row_bytes, "byte count past padded row")
  `PPRU_ASSERT_ALWAYS(a_row_in_img, row_r < eff_h, "row count past image height")
  `PPRU_ASSERT_NEXT(a_cfg_clears, cfg_hit, counters_zero, "config write did not restart image")

endmodule

@@ design/ppru_pixel_gen.sv @@
// ----------------------------------------------------------------------------
// Packed pixel unpacker pixel generator
// Holds one source byte and emits its pixels into the result register, one
// per cycle unless stalled, with end-of-row, end-of-image, last-of-byte flags.
// ----------------------------------------------------------------------------
module ppru_pixel_gen (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_load,
  input  ppru_pkg::ppru_job_t  job,
  output logic                 job_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [14:0]          out_pixel_rgb555,
  output logic                 out_row_end,
  output logic                 out_image_end,
  output logic                 out_last_of_byte
);
  import ppru_pkg::*;

  ppru_job_t          job_r;
  logic               job_valid_r;
  logic [2:0]         idx_r;
  logic               out_valid_r;
  logic [PIX_W-1:0]   pixel_r;
  logic               row_end_r;
  logic               image_end_r;
  logic               last_r;

  logic               out_move;
  logic               work_fire;
  logic               last_k;
  logic               work_done;
  logic [3:0]         nib;
  logic [PIX_W-1:0]   pix_nxt;

  assign out_move  = !out_valid_r || out_ready;
  assign work_fire = job_valid_r && out_move;
  assign last_k    = ({1'b0, idx_r} == (job_r.count - 4'd1));
  assign work_done = work_fire && last_k;
  assign job_ready = !job_valid_r || work_done;

  always_comb begin
    nib = idx_r[0] ? job_r.src_byte[3:0] : job_r.src_byte[7:4];
    if (job_r.four_bit) begin
      pix_nxt = PIX_BLACK;
      if (nib[0]) pix_nxt = pix_nxt | PIX_RED;
      if (nib[1]) pix_nxt = pix_nxt | PIX_GREEN;
      if (nib[2]) pix_nxt = pix_nxt | PIX_BLUE;
    end else begin
      pix_nxt = job_r.src_byte[3'd7 - idx_r] ? PIX_WHITE : PIX_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (job_load) begin
      job_valid_r <= 1'b1;
      idx_r       <= 3'd0;
    end else if (work_done) begin
      job_valid_r <= 1'b0;
    end else if (work_fire) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= job_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work_fire) begin
      pixel_r     <= pix_nxt;
      row_end_r   <= last_k && job_r.row_end;
      image_end_r <= last_k && job_r.row_end && job_r.last_row;
      last_r      <= last_k;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_rgb555 = pixel_r;
  assign out_row_end      = row_end_r;
  assign out_image_end    = image_end_r;
  assign out_last_of_byte = last_r;

endmodule
